// ===== hw/rtl/oahm_pkg.sv =====
// Shared types and constants for the open-address hash map.
`default_nettype none

package oahm_pkg;

  localparam int KEY_W      = 32;
  localparam int HASH_W     = 32;
  localparam int VALUE_W    = 32;
  localparam int SLOT_W     = 7;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = HASH_W + KEY_W + VALUE_W;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_FOLD,
    S_MOD,
    S_BREAD,
    S_BCHK,
    S_ECHK,
    S_DONE
  } state_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_ABSENT   = 3'd1,
    ST_INSERTED = 3'd2,
    ST_REPLACED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oahm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module oahm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/oahm_reduce.sv =====
// Shared compare-and-subtract unit that reduces a value below twice the bucket count.
`default_nettype none

module oahm_reduce #(
  parameter int BUCKETS = 251
) (
  input  logic [$clog2(BUCKETS)+1:0] a,
  output logic [$clog2(BUCKETS)-1:0] y
);

  localparam int BW = $clog2(BUCKETS);
  localparam int UW = BW + 2;

  logic [UW-1:0] diff;

  assign diff = a - UW'(BUCKETS);
  assign y    = (a >= UW'(BUCKETS)) ? diff[BW-1:0] : a[BW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/open_address_hash_map_top.sv =====
// Top level of the open-address hash map: sequencer, bucket store and entry store.
`default_nettype none

// Key/value map with triangular probing over BUCKETS buckets that index a dense store of
// up to ENTRIES entries. After reset the block writes every bucket of the bucket store
// empty and holds s_axis_tready low meanwhile. A request then passes an accept step and
// the steps in which a reciprocal multiplication, a fold and one pass through the shared
// compare-and-subtract unit reduce the hash modulo BUCKETS. Each probe reads a bucket and
// checks it; a probe whose bucket points at a live entry also reads and compares that
// entry. A last step hands the result to the output register. While the output register
// holds a result that has not been taken, the block waits in its last step.

module open_address_hash_map_top
  import oahm_pkg::*;
#(
  parameter int BUCKETS = 251,
  parameter int ENTRIES = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // key [31:0], hash [63:32], value [95:64]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_value [31:0], slot_index [38:32], zero [39]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  localparam int BW = $clog2(BUCKETS);
  localparam int UW = BW + 2;
  localparam int EW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TW = $clog2(BUCKETS + 2);
  localparam logic [EW-1:0] EMPTY = {EW{1'b1}};
  localparam logic [2*HASH_W-1:0] RECIP_WIDE = (64'd1 << HASH_W) / 64'(BUCKETS);
  localparam logic [HASH_W-1:0] RECIP = RECIP_WIDE[HASH_W-1:0];

  state_t               state, state_next;
  logic [BW-1:0]        clr_addr;
  logic                 kind_r;
  logic [KEY_W-1:0]     key_r;
  logic [HASH_W-1:0]    hash_r;
  logic [VALUE_W-1:0]   value_r;
  logic [HASH_W-1:0]    quot;
  logic [UW-1:0]        rem_r;
  logic [BW-1:0]        b;
  logic [BW-1:0]        b0;
  logic [TW-1:0]        tries;
  logic [EW-1:0]        cur_e;
  logic [EW-1:0]        count;
  status_t              res_status;
  logic [VALUE_W-1:0]   res_value;
  logic [SLOT_W-1:0]    res_slot;

  logic                 bkt_we;
  logic [BW-1:0]        bkt_waddr;
  logic [EW-1:0]        bkt_wdata;
  logic [BW-1:0]        bkt_raddr;
  logic [EW-1:0]        bkt_rdata;
  logic                 ent_we;
  logic [IW-1:0]        ent_waddr;
  logic [ENTRY_W-1:0]   ent_wdata;
  logic [IW-1:0]        ent_raddr;
  logic [ENTRY_W-1:0]   ent_rdata;

  logic [2*HASH_W-1:0]  recip_prod;
  logic [UW-1:0]        fold_prod;
  logic [UW-1:0]        unit_a;
  logic [BW-1:0]        unit_y;
  logic [TW-1:0]        tries_new;
  logic                 bkt_empty;
  logic                 bkt_live;
  logic                 ent_hit;
  logic                 step_fail;
  logic                 can_insert;
  logic                 do_step;
  logic                 res_load;
  status_t              status_next;
  logic [VALUE_W-1:0]   value_next;
  logic [SLOT_W-1:0]    slot_next;
  logic                 out_free;

  oahm_ram #(
    .WIDTH (EW),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  oahm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  oahm_reduce #(
    .BUCKETS (BUCKETS)
  ) u_reduce (
    .a (unit_a),
    .y (unit_y)
  );

  // The estimated quotient is at most one below the true one, so the fold stays below
  // twice the bucket count and one pass through the shared unit finishes the reduction.
  assign recip_prod = (2*HASH_W)'(hash_r) * (2*HASH_W)'(RECIP);
  assign fold_prod  = quot[UW-1:0] * UW'(BUCKETS);

  assign tries_new  = tries + 1'b1;
  assign bkt_empty  = (bkt_rdata == EMPTY);
  assign bkt_live   = (bkt_rdata < count);
  assign ent_hit    = (ent_rdata[ENTRY_W-1 -: HASH_W] == hash_r) &&
                      (ent_rdata[VALUE_W +: KEY_W] == key_r);
  assign step_fail  = (tries_new == TW'(BUCKETS + 1)) || (unit_y == b0);
  assign can_insert = (count < EW'(ENTRIES));
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_FOLD;
      end
      S_FOLD: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        state_next = S_BREAD;
      end
      S_BREAD: begin
        state_next = S_BCHK;
      end
      S_BCHK: begin
        if (bkt_empty) begin
          state_next = S_DONE;
        end else if (bkt_live) begin
          state_next = S_ECHK;
        end else if (step_fail) begin
          state_next = S_DONE;
        end else begin
          state_next = S_BREAD;
        end
      end
      S_ECHK: begin
        if (ent_hit || step_fail) begin
          state_next = S_DONE;
        end else begin
          state_next = S_BREAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    bkt_we        = 1'b0;
    bkt_waddr     = b;
    bkt_wdata     = count;
    bkt_raddr     = b;
    ent_we        = 1'b0;
    ent_waddr     = count[IW-1:0];
    ent_wdata     = {hash_r, key_r, value_r};
    ent_raddr     = bkt_rdata[IW-1:0];
    unit_a        = UW'(b) + UW'(tries_new);
    do_step       = 1'b0;
    res_load      = 1'b0;
    status_next   = ST_ABSENT;
    value_next    = '0;
    slot_next     = '0;
    unique case (state)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_addr;
        bkt_wdata = EMPTY;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_MUL: begin
      end
      S_FOLD: begin
      end
      S_MOD: begin
        unit_a = rem_r;
      end
      S_BREAD: begin
      end
      S_BCHK: begin
        if (bkt_empty) begin
          res_load = 1'b1;
          if (!kind_r) begin
            status_next = ST_ABSENT;
          end else if (can_insert) begin
            status_next = ST_INSERTED;
            slot_next   = SLOT_W'(count);
            bkt_we      = 1'b1;
            ent_we      = 1'b1;
          end else begin
            status_next = ST_FULL;
          end
        end else if (!bkt_live) begin
          do_step = 1'b1;
          if (step_fail) begin
            res_load    = 1'b1;
            status_next = kind_r ? ST_FULL : ST_ABSENT;
          end
        end
      end
      S_ECHK: begin
        ent_waddr = cur_e[IW-1:0];
        if (ent_hit) begin
          res_load  = 1'b1;
          slot_next = SLOT_W'(cur_e);
          if (kind_r) begin
            status_next = ST_REPLACED;
            ent_we      = 1'b1;
          end else begin
            status_next = ST_FOUND;
            value_next  = ent_rdata[VALUE_W-1:0];
          end
        end else begin
          do_step = 1'b1;
          if (step_fail) begin
            res_load    = 1'b1;
            status_next = kind_r ? ST_FULL : ST_ABSENT;
          end
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (bkt_we && state != S_CLEAR) begin
        count <= count + 1'b1;
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      kind_r  <= s_axis_tuser[0];
      key_r   <= s_axis_tdata[KEY_W-1:0];
      hash_r  <= s_axis_tdata[KEY_W +: HASH_W];
      value_r <= s_axis_tdata[KEY_W + HASH_W +: VALUE_W];
    end
    if (state == S_MUL) begin
      quot <= recip_prod[2*HASH_W-1:HASH_W];
    end
    if (state == S_FOLD) begin
      rem_r <= hash_r[UW-1:0] - fold_prod;
    end
    if (state == S_MOD) begin
      b     <= unit_y;
      b0    <= unit_y;
      tries <= '0;
    end
    if (state == S_BCHK) begin
      cur_e <= bkt_rdata;
    end
    if (do_step) begin
      b     <= unit_y;
      tries <= tries_new;
    end
    if (res_load) begin
      res_status <= status_next;
      res_value  <= value_next;
      res_slot   <= slot_next;
    end
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {1'b0, res_slot, res_value};
      m_axis_tuser <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= EW'(ENTRIES))
    else $error("Entry count exceeds the entry store.");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BREAD || state == S_BCHK || state == S_ECHK) |->
      ({1'b0, b} < (BW + 1)'(BUCKETS)))
    else $error("Probe bucket outside the bucket store.");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCHK && bkt_we) |=> (count == EW'($past(count) + 1'b1)))
    else $error("Insert did not advance the entry count.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_DONE))
    else $error("Result presented outside the completion step.");

  a_insert_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCHK && bkt_we) |=> (res_status == ST_INSERTED))
    else $error("Bucket written without an insert result.");

endmodule

`default_nettype wire

// ===== sim/open_address_hash_map_top_tb.sv =====
// Self-checking testbench for the open-address hash map: directed, chain-fill and random traffic.

module open_address_hash_map_top_tb
  import oahm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKETS = 251;
  localparam int ENTRIES = 128;
  localparam int EMPTY_BUCKET = -1;
  localparam logic [31:0] CHAIN_HASH_TOP = 32'd4294967173;
  localparam int CHAIN_MULT_MAX = 17111423;
  localparam int RANDOM_ITEMS = 1450;
  localparam int STALL_LIMIT = 5000;
  localparam int END_SETTLE = 800;
  localparam int MAX_PRINTED = 100;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_SET    = 1'b1
  } map_op_t;

  typedef enum int {
    PROBE_HIT,
    PROBE_EMPTY,
    PROBE_WRAPPED
  } probe_end_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [6:0]  slot;
  } map_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // key [31:0], hash [63:32], value [95:64]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // kind [0]
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // read_value [31:0], slot_index [38:32], zero [39]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // status [2:0]
  logic [STATUS_W-1:0]   m_axis_tuser;

  int          bucket_entry [BUCKETS];
  logic [31:0] entry_key [ENTRIES];
  logic [31:0] entry_hash [ENTRIES];
  logic [31:0] entry_value [ENTRIES];
  int          stored_count = 0;

  map_result_t pending_results[$];
  int          mismatch_count = 0;
  int          hold_off_cycles = 0;
  bit          idle_off = 1'b0;

  open_address_hash_map_top #(
    .BUCKETS(BUCKETS),
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (idle_off) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] chain_hash();
    return 32'(BUCKETS) * 32'($urandom_range(0, CHAIN_MULT_MAX));
  endfunction

  function automatic void walk_probe(input logic [31:0] key, input logic [31:0] hash,
                                     output probe_end_t outcome, output int bkt,
                                     output int ent);
    int start;
    int b;
    int tries;
    start = int'(hash % 32'(BUCKETS));
    b = start;
    tries = 0;
    outcome = PROBE_WRAPPED;
    bkt = 0;
    ent = 0;
    for (int guard = 0; guard <= BUCKETS; guard++) begin
      if (bucket_entry[b] == EMPTY_BUCKET) begin
        outcome = PROBE_EMPTY;
        bkt = b;
        return;
      end
      if (bucket_entry[b] < stored_count && entry_hash[bucket_entry[b]] == hash &&
          entry_key[bucket_entry[b]] == key) begin
        outcome = PROBE_HIT;
        bkt = b;
        ent = bucket_entry[b];
        return;
      end
      tries++;
      b = (b + tries) % BUCKETS;
      if (b == start) return;
    end
  endfunction

  function automatic map_result_t predict_access(input map_op_t op, input logic [31:0] key,
                                                 input logic [31:0] hash,
                                                 input logic [31:0] value);
    map_result_t res;
    probe_end_t  outcome;
    int          bkt;
    int          ent;
    res = '{status: ST_ABSENT, read_value: '0, slot: '0};
    walk_probe(key, hash, outcome, bkt, ent);
    if (op == OP_LOOKUP) begin
      if (outcome == PROBE_HIT) begin
        res.status = ST_FOUND;
        res.read_value = entry_value[ent];
        res.slot = 7'(ent);
      end
    end else if (outcome == PROBE_HIT) begin
      entry_value[ent] = value;
      res.status = ST_REPLACED;
      res.slot = 7'(ent);
    end else if (outcome == PROBE_WRAPPED || stored_count >= ENTRIES) begin
      res.status = ST_FULL;
    end else begin
      ent = stored_count;
      entry_key[ent] = key;
      entry_hash[ent] = hash;
      entry_value[ent] = value;
      bucket_entry[bkt] = ent;
      stored_count = ent + 1;
      res.status = ST_INSERTED;
      res.slot = 7'(ent);
    end
    return res;
  endfunction

  function automatic bit chain_has_room(input int start);
    int b;
    b = start;
    for (int step = 1; step <= BUCKETS; step++) begin
      if (bucket_entry[b] == EMPTY_BUCKET) return 1'b1;
      b = (b + step) % BUCKETS;
      if (b == start) return 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH: %s", what);
  endtask

  task automatic send_request(input map_op_t op, input logic [31:0] key,
                              input logic [31:0] hash, input logic [31:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {value, hash, key};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_access(op, key, hash, value));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result check: every transaction on the output is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    map_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
        if (m_axis_tdata[31:0] !== want.read_value)
          report_mismatch($sformatf("read_value %h, expected %h", m_axis_tdata[31:0],
                                    want.read_value));
        if (m_axis_tdata[38:32] !== want.slot)
          report_mismatch($sformatf("slot_index %0d, expected %0d", m_axis_tdata[38:32],
                                    want.slot));
      end
    end
  end

  initial begin : result_sink
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) gap = draw_gap();
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_cycles--;
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Inserts all land on the probe chain that starts at bucket zero.
  task automatic test_basic_access();
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SET, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_SET, 32'hFFFF_FFFF, CHAIN_HASH_TOP, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, CHAIN_HASH_TOP, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h0000_0000, CHAIN_HASH_TOP, 32'h0000_0000);
    send_request(OP_SET, 32'h0000_0000, 32'h0000_0000, 32'h5A5A_5A5A);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_SET, 32'h1234_5678, 32'd251, 32'hA5A5_A5A5);
    send_request(OP_LOOKUP, 32'h1234_5678, 32'd251, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_LOOKUP, $urandom, 32'd250, $urandom);
    send_request(OP_SET, 32'hFFFF_FFFF, CHAIN_HASH_TOP, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, CHAIN_HASH_TOP, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_probe_chain_fill();
    int idx;
    while (chain_has_room(0) && stored_count < ENTRIES) begin
      if ($urandom_range(0, 99) < 30) begin
        idx = $urandom_range(0, stored_count - 1);
        send_request(map_op_t'($urandom_range(0, 1)), entry_key[idx], entry_hash[idx],
                     $urandom);
      end else begin
        send_request(OP_SET, $urandom, chain_hash(), $urandom);
      end
    end
    drain_results();
  endtask

  task automatic test_no_empty_bucket();
    int idx;
    idx = stored_count - 1;
    send_request(OP_SET, $urandom, chain_hash(), $urandom);
    send_request(OP_LOOKUP, $urandom, chain_hash(), $urandom);
    send_request(OP_SET, entry_key[idx], entry_hash[idx], $urandom);
    send_request(OP_LOOKUP, entry_key[idx], entry_hash[idx], $urandom);
    drain_results();
  endtask

  task automatic test_store_full();
    int tries;
    int idx;
    tries = 0;
    while (stored_count < ENTRIES && tries < 20) begin
      send_request(OP_SET, $urandom, $urandom, $urandom);
      tries++;
    end
    idx = stored_count - 1;
    send_request(OP_SET, $urandom, $urandom, $urandom);
    send_request(OP_SET, entry_key[idx], entry_hash[idx], 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, entry_key[idx], entry_hash[idx], 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    int idx;
    hold_off_cycles = 300;
    for (int n = 0; n < 6; n++) begin
      idx = $urandom_range(0, stored_count - 1);
      send_request(OP_LOOKUP, entry_key[idx], entry_hash[idx], $urandom);
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int pick;
    int idx;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_off = ((n / 200) % 3 == 2);
      pick = $urandom_range(0, 99);
      idx = $urandom_range(0, stored_count - 1);
      if (pick < 35)
        send_request(OP_LOOKUP, entry_key[idx], entry_hash[idx], $urandom);
      else if (pick < 60)
        send_request(OP_SET, entry_key[idx], entry_hash[idx], $urandom);
      else if (pick < 70)
        send_request(OP_LOOKUP, $urandom, entry_hash[idx], $urandom);
      else if (pick < 80)
        send_request(OP_LOOKUP, entry_key[idx], $urandom, $urandom);
      else if (pick < 90)
        send_request(OP_SET, $urandom, $urandom, $urandom);
      else if (pick < 97)
        send_request(map_op_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      else
        send_request(map_op_t'($urandom_range(0, 1)), $urandom, chain_hash(), $urandom);
    end
    idle_off = 1'b0;
  endtask

  initial begin : main_sequence
    for (int b = 0; b < BUCKETS; b++) bucket_entry[b] = EMPTY_BUCKET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic_access();
    test_probe_chain_fill();
    test_no_empty_bucket();
    test_store_full();
    test_output_backpressure();
    test_random_traffic();
    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
